// File: rtl/core/tops_pkg.sv
`timescale 1ns / 1ps

package tops_pkg;

  // default pattern depth
  localparam int MAX_STEPS_DEF = 16;

  // pattern entry layout: level in the top bit, duration below it
  localparam int ENTRY_W  = 32;
  localparam int DUR_W    = 31;
  localparam int LEVEL_IX = 31;

  // widest entry index carried between modules
  localparam int ADDR_MAX_W = 8;

  // item codes
  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_ON    = 3'd1,
    ACT_OFF   = 3'd2,
    ACT_BEEP  = 3'd3,
    ACT_START = 3'd4,
    ACT_WRITE = 3'd5
  } tops_action_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SVC,
    ST_FINISH
  } tops_state_t;

  // write request toward the pattern memory
  typedef struct packed {
    logic                  en;
    logic [ADDR_MAX_W-1:0] addr;
    logic [ENTRY_W-1:0]    data;
  } tops_wr_t;

endpackage

// File: rtl/core/tops_step_mem.sv
`timescale 1ns / 1ps

module tops_step_mem
  import tops_pkg::*;
#(
  parameter int DEPTH  = MAX_STEPS_DEF,
  parameter int ADDR_W = 4
) (
  input  logic               clk,
  input  tops_wr_t           wr,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/tops_ctrl.sv
`timescale 1ns / 1ps

module tops_ctrl
  import tops_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic [31:0]        now_time,
  input  logic [30:0]        beep_length,
  input  logic [4:0]         seq_length,
  input  logic [3:0]         entry_slot,
  input  logic               entry_level,
  input  logic [30:0]        entry_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               buzzer_on_level,
  output logic               sequence_running,
  output logic [3:0]         step_position,
  output tops_wr_t           wr,
  output logic [IDX_W-1:0]   rd_addr,
  input  logic [ENTRY_W-1:0] rd_data
);

  tops_state_t state, state_next;

  logic [CNT_W-1:0] step_total, step_total_next;
  logic [IDX_W-1:0] step_now, step_now_next;
  logic [31:0]      due_ms, due_ms_next;
  logic             busy, busy_next;
  logic             level_reg, level_reg_next;
  logic [31:0]      now_q;
  logic             out_valid_next;

  logic             accept;
  logic             out_free;
  logic             expired;
  logic             more_steps;
  logic [31:0]      diff;
  logic [8:0]       rd_pick;
  logic [8:0]       seq_ext;
  logic [7:0]       pos_ext;
  tops_action_t     act;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign act      = tops_action_t'(action);

  // wrap-safe deadline test and step count check
  assign diff       = now_q - due_ms;
  assign expired    = busy && !diff[31];
  assign more_steps = ((CNT_W + 1)'(step_now) + (CNT_W + 1)'(1)) < (CNT_W + 1)'(step_total);
  assign seq_ext    = 9'(seq_length);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_TICK:  state_next = ST_SVC;
            ACT_BEEP:  state_next = ST_SVC;
            ACT_START: state_next = (seq_length == 5'd0) ? ST_FINISH : ST_START;
            default:   state_next = ST_FINISH;
          endcase
        end
      end
      ST_START:  state_next = ST_SVC;
      ST_SVC: begin
        if (!expired || !more_steps) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // timing state updates and memory requests
  always_comb begin
    step_total_next = step_total;
    step_now_next   = step_now;
    due_ms_next     = due_ms;
    busy_next       = busy;
    level_reg_next  = level_reg;
    out_valid_next  = out_valid && !out_ready;
    wr.en           = 1'b0;
    wr.addr         = ADDR_MAX_W'(entry_slot);
    wr.data         = {entry_level, entry_time};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_ON, ACT_OFF: begin
              step_total_next = '0;
              step_now_next   = '0;
              busy_next       = 1'b0;
              level_reg_next  = (act == ACT_ON);
            end
            ACT_BEEP: begin
              step_total_next = '0;
              step_now_next   = '0;
              busy_next       = 1'b1;
              level_reg_next  = 1'b1;
              due_ms_next     = now_time + {1'b0, beep_length};
            end
            ACT_START: begin
              if (seq_length == 5'd0) begin
                step_total_next = '0;
                step_now_next   = '0;
                busy_next       = 1'b0;
                level_reg_next  = 1'b0;
              end else if (seq_ext > 9'(MAX_STEPS)) begin
                step_total_next = CNT_W'(MAX_STEPS);
              end else begin
                step_total_next = CNT_W'(seq_length);
              end
            end
            ACT_WRITE: begin
              wr.en = (9'(entry_slot) < 9'(MAX_STEPS));
            end
            default: begin
            end
          endcase
        end
      end
      // entry 0 arrives from memory
      ST_START: begin
        step_now_next  = '0;
        busy_next      = 1'b1;
        level_reg_next = rd_data[LEVEL_IX];
        due_ms_next    = now_q + {1'b0, rd_data[DUR_W-1:0]};
      end
      // one expired step per cycle, next entry prefetched
      ST_SVC: begin
        if (expired) begin
          if (more_steps) begin
            step_now_next  = step_now + IDX_W'(1);
            level_reg_next = rd_data[LEVEL_IX];
            due_ms_next    = due_ms + {1'b0, rd_data[DUR_W-1:0]};
          end else begin
            step_total_next = '0;
            step_now_next   = '0;
            busy_next       = 1'b0;
            level_reg_next  = 1'b0;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // read address: entry 0 for a pattern start or past the last slot, else the step after the next one
  always_comb begin
    rd_pick = 9'(step_now_next) + 9'd1;
    if (state == ST_IDLE && act == ACT_START) begin
      rd_addr = '0;
    end else if (rd_pick < 9'(MAX_STEPS)) begin
      rd_addr = IDX_W'(rd_pick);
    end else begin
      rd_addr = '0;
    end
  end

  assign pos_ext = 8'(step_now);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step_total <= '0;
      step_now   <= '0;
      due_ms     <= '0;
      busy       <= 1'b0;
      level_reg  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      step_total <= step_total_next;
      step_now   <= step_now_next;
      due_ms     <= due_ms_next;
      busy       <= busy_next;
      level_reg  <= level_reg_next;
      out_valid  <= out_valid_next;
    end
  end

  // item time and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      now_q <= now_time;
    end
    if (state == ST_FINISH && out_free) begin
      buzzer_on_level  <= level_reg;
      sequence_running <= busy;
      step_position    <= pos_ext[3:0];
    end
  end

endmodule

// File: rtl/core/timed_on_off_pattern_sequencer.sv
`timescale 1ns / 1ps
// channel  | signals                                         | direction
// input    | in_valid, in_ready, action, now_time,           | in
//          | beep_length, seq_length, entry_slot,            |
//          | entry_level, entry_time                         |
// output   | out_valid, out_ready, buzzer_on_level,          | out
//          | sequence_running, step_position                 |
//
// force on/off, entry write, a zero-length start and unused codes go straight to finish.
// a tick or a timed beep passes through service, any other pattern start through start,
// then service; the pattern memory yields one step per cycle.
// synchronous reset clears the timing state and out_valid, not the payload or the memory.
// a new transaction is taken while the last result still waits on out_ready;
// a held result stalls only the finish of the following transaction.

module timed_on_off_pattern_sequencer
  import tops_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [31:0] now_time,
  input  logic [30:0] beep_length,
  input  logic [4:0]  seq_length,
  input  logic [3:0]  entry_slot,
  input  logic        entry_level,
  input  logic [30:0] entry_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        buzzer_on_level,
  output logic        sequence_running,
  output logic [3:0]  step_position
);

  localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CNT_W = $clog2(MAX_STEPS + 1);

  tops_wr_t           wr;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  // sequencer control and timing state
  tops_ctrl #(
    .MAX_STEPS (MAX_STEPS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .now_time         (now_time),
    .beep_length      (beep_length),
    .seq_length       (seq_length),
    .entry_slot       (entry_slot),
    .entry_level      (entry_level),
    .entry_time       (entry_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .buzzer_on_level  (buzzer_on_level),
    .sequence_running (sequence_running),
    .step_position    (step_position),
    .wr               (wr),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data)
  );

  // pattern step storage
  tops_step_mem #(
    .DEPTH  (MAX_STEPS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
